### sv/audio_abs_stats_and_sample_ring_defines.svh
// Assertion macros shared by the sample ring RTL.
`ifndef AUDIO_ABS_STATS_AND_SAMPLE_RING_DEFINES_SVH
`define AUDIO_ABS_STATS_AND_SAMPLE_RING_DEFINES_SVH

`ifndef SYNTHESIS
// Check an implication or expression on every clock edge out of reset.
`define AASR_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("aasr check failed");
// Flag a condition that must never occur.
`define AASR_NEVER(name, cond) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("aasr forbidden condition");
`else
`define AASR_ASSERT(name, prop)
`define AASR_NEVER(name, cond)
`endif

`endif

### sv/aasr_pkg.sv
package aasr_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 48;
    localparam int CNT_W    = 32;
    localparam int POS_W    = 32;
    localparam int LIM_W    = 7;
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_DRAIN = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_DRAIN,
        CMD_READ
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind             kind;
        logic [SAMPLE_W-1:0]   raw;
        logic [SAMPLE_W-1:0]   mag;
        logic [LIM_W-1:0]      limit;
    } t_cmd;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_PLAN,
        BS_EMIT
    } t_bstate;

endpackage

### sv/aasr_front.sv
module aasr_front #(
    parameter int MAX_BURST = 64
) (
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_operation,
    input  logic signed [15:0]            i_sample,
    input  logic [6:0]                    i_max_count,
    input  logic                          i_full,
    output logic                          o_push,
    output aasr_pkg::t_cmd                o_cmd
);
    import aasr_pkg::*;

    localparam logic [LIM_W-1:0] BURST_LIM = LIM_W'(MAX_BURST);

    logic [SAMPLE_W-1:0] raw;
    logic                known;

    assign busy = i_full;
    assign raw  = i_sample;

    always_comb begin
        o_cmd.raw   = raw;
        // two's complement negation gives 32768 for the most negative code
        o_cmd.mag   = raw[SAMPLE_W-1] ? (~raw + SAMPLE_W'(1)) : raw;
        o_cmd.limit = (i_max_count > BURST_LIM) ? BURST_LIM : i_max_count;
        o_cmd.kind  = CMD_PUSH;
        known       = 1'b1;
        case (t_op'(i_operation))
            OP_PUSH:  o_cmd.kind = CMD_PUSH;
            OP_DRAIN: o_cmd.kind = CMD_DRAIN;
            OP_READ:  o_cmd.kind = CMD_READ;
            default:  known      = 1'b0;
        endcase
    end

    // drop unused codes: accepted, no effect
    assign o_push = start & ~i_full & known;

endmodule

### sv/aasr_cmd_queue.sv
module aasr_cmd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  aasr_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output aasr_pkg::t_cmd    o_head,
    output logic              o_head_valid,
    output logic              o_full
);
    import aasr_pkg::*;

    t_cmd               r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_PTR_W:0]   r_fill,   n_fill;
    logic               do_pop;

    assign do_pop       = i_pop & (r_fill != '0);
    assign o_head       = r_slot[r_rd_ptr];
    assign o_head_valid = (r_fill != '0);
    assign o_full       = (r_fill == (Q_PTR_W+1)'(Q_DEPTH));

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + Q_PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = r_rd_ptr + Q_PTR_W'(1);
        end
        case ({i_push, do_pop})
            2'b10:   n_fill = r_fill + (Q_PTR_W+1)'(1);
            2'b01:   n_fill = r_fill - (Q_PTR_W+1)'(1);
            default: n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### sv/aasr_back.sv
`include "audio_abs_stats_and_sample_ring_defines.svh"

module aasr_back #(
    parameter int RING_DEPTH = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  aasr_pkg::t_cmd        i_head,
    input  logic                  i_head_valid,
    output logic                  o_pop,
    output logic                  o_result_strobe,
    output logic [47:0]           o_sum_abs,
    output logic [31:0]           o_sample_count,
    output logic [15:0]           o_max_abs,
    output logic signed [15:0]    o_ring_sample,
    output logic                  o_sample_valid,
    output logic [6:0]            o_copied,
    output logic                  o_is_last
);
    import aasr_pkg::*;

    localparam int               AW        = $clog2(RING_DEPTH);
    localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(RING_DEPTH);

    logic [SAMPLE_W-1:0] r_ring [RING_DEPTH];
    logic [SAMPLE_W-1:0] r_mem_q;

    t_bstate             r_state, n_state;
    logic [SUM_W-1:0]    r_sum,   n_sum;
    logic [CNT_W-1:0]    r_cnt,   n_cnt;
    logic [SAMPLE_W-1:0] r_peak,  n_peak;
    logic [POS_W-1:0]    r_wp,    n_wp;
    logic [POS_W-1:0]    r_rp,    n_rp;
    logic [POS_W-1:0]    r_avail, n_avail;
    logic [LIM_W-1:0]    r_limit, n_limit;
    logic [LIM_W-1:0]    r_left,  n_left;
    logic [LIM_W-1:0]    r_take,  n_take;

    logic                r_strobe,  n_strobe;
    logic                r_o_valid, n_o_valid;
    logic                r_o_last,  n_o_last;
    logic [LIM_W-1:0]    r_o_copied, n_o_copied;
    logic [SUM_W-1:0]    r_o_sum,   n_o_sum;
    logic [CNT_W-1:0]    r_o_cnt,   n_o_cnt;
    logic [SAMPLE_W-1:0] r_o_max,   n_o_max;

    logic                mem_we;
    logic                rd_en;
    logic [SUM_W:0]      sum_ext;
    logic [POS_W-1:0]    avail_c;

    always_comb begin
        n_state    = r_state;
        n_sum      = r_sum;
        n_cnt      = r_cnt;
        n_peak     = r_peak;
        n_wp       = r_wp;
        n_rp       = r_rp;
        n_avail    = r_avail;
        n_limit    = r_limit;
        n_left     = r_left;
        n_take     = r_take;
        n_strobe   = 1'b0;
        n_o_valid  = 1'b0;
        n_o_last   = 1'b0;
        n_o_copied = '0;
        n_o_sum    = '0;
        n_o_cnt    = '0;
        n_o_max    = '0;
        o_pop      = 1'b0;
        mem_we     = 1'b0;
        rd_en      = 1'b0;
        sum_ext    = {1'b0, r_sum} + (SUM_W+1)'(i_head.mag);
        avail_c    = (r_avail > DEPTH_POS) ? DEPTH_POS : r_avail;

        case (r_state)
            BS_IDLE: begin
                if (i_head_valid) begin
                    o_pop = 1'b1;
                    case (i_head.kind)
                        CMD_PUSH: begin
                            n_sum  = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
                            n_cnt  = (&r_cnt) ? r_cnt : r_cnt + CNT_W'(1);
                            n_peak = (i_head.mag > r_peak) ? i_head.mag : r_peak;
                            mem_we = 1'b1;
                            n_wp   = r_wp + POS_W'(1);
                        end
                        CMD_DRAIN: begin
                            n_strobe = 1'b1;
                            n_o_last = 1'b1;
                            n_o_sum  = r_sum;
                            n_o_cnt  = r_cnt;
                            n_o_max  = r_peak;
                            n_sum    = '0;
                            n_cnt    = '0;
                            n_peak   = '0;
                        end
                        CMD_READ: begin
                            n_limit = i_head.limit;
                            n_avail = r_wp - r_rp;
                            n_state = BS_PLAN;
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            BS_PLAN: begin
                if (r_avail == '0 || r_limit == '0) begin
                    n_strobe = 1'b1;
                    n_o_last = 1'b1;
                    n_state  = BS_IDLE;
                end else begin
                    // skip ahead when the reader lost a whole ring
                    if (r_avail > DEPTH_POS) begin
                        n_rp = r_wp - DEPTH_POS;
                    end
                    n_take  = (avail_c < POS_W'(r_limit)) ? avail_c[LIM_W-1:0] : r_limit;
                    n_left  = n_take;
                    n_state = BS_EMIT;
                end
            end
            BS_EMIT: begin
                rd_en      = 1'b1;
                n_rp       = r_rp + POS_W'(1);
                n_left     = r_left - LIM_W'(1);
                n_strobe   = 1'b1;
                n_o_valid  = 1'b1;
                n_o_copied = r_take;
                n_o_last   = (r_left == LIM_W'(1));
                if (r_left == LIM_W'(1)) begin
                    n_state = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_sum    <= '0;
            r_cnt    <= '0;
            r_peak   <= '0;
            r_wp     <= '0;
            r_rp     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sum    <= n_sum;
            r_cnt    <= n_cnt;
            r_peak   <= n_peak;
            r_wp     <= n_wp;
            r_rp     <= n_rp;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_avail    <= n_avail;
        r_limit    <= n_limit;
        r_left     <= n_left;
        r_take     <= n_take;
        r_o_valid  <= n_o_valid;
        r_o_last   <= n_o_last;
        r_o_copied <= n_o_copied;
        r_o_sum    <= n_o_sum;
        r_o_cnt    <= n_o_cnt;
        r_o_max    <= n_o_max;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[r_wp[AW-1:0]] <= i_head.raw;
        end
        if (rd_en) begin
            r_mem_q <= r_ring[r_rp[AW-1:0]];
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_sum_abs       = r_o_sum;
    assign o_sample_count  = r_o_cnt;
    assign o_max_abs       = r_o_max;
    assign o_ring_sample   = r_o_valid ? r_mem_q : '0;
    assign o_sample_valid  = r_o_valid;
    assign o_copied        = r_o_copied;
    assign o_is_last       = r_o_last;

    `AASR_ASSERT(a_emit_has_work, (r_state == BS_EMIT) |-> (r_left != '0))
    `AASR_NEVER(n_write_during_emit, mem_we && (r_state != BS_IDLE))
    `AASR_ASSERT(a_valid_counts, (r_strobe && r_o_valid) |-> (r_o_copied != '0))
    `AASR_ASSERT(a_last_ends_burst, (r_strobe && r_o_last && r_o_valid) |-> (r_state == BS_IDLE))

endmodule

### sv/audio_abs_stats_and_sample_ring.sv
// Microphone sample ring with absolute-level statistics.
// Command channel: drive i_operation, i_sample and i_max_count with start
// high; the command is taken at a clock edge where busy is low. Push (0)
// folds |sample| into the saturating sum, count and peak and writes the
// sample into the ring; drain (1) returns sum, count and peak as one beat
// and clears them; read (2) returns up to i_max_count unread samples,
// oldest first, one beat per cycle, the final beat marked by o_is_last.
// An empty read gives a single beat with o_sample_valid low. Code 3 is
// taken and ignored.
// Commands pass through a two-entry queue to the execution unit, so busy
// rises only while the queue is full. The unit takes a push straight from
// BS_IDLE, so pushes run at one per cycle while no read burst holds the
// queue. A drain beat passes through the queue slot and the result
// registers; a read works out the span in BS_PLAN, then gives its beats
// from BS_EMIT, paced by the single read port of the ring memory.
// Result beats last exactly one cycle under o_result_strobe; there is no
// back-pressure. Synchronous reset clears statistics, positions and queue;
// ring contents are left as they are.
module audio_abs_stats_and_sample_ring #(
    parameter int RING_DEPTH = 512,
    parameter int MAX_BURST  = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_operation,
    input  logic signed [15:0] i_sample,
    input  logic [6:0]         i_max_count,
    output logic               o_result_strobe,
    output logic [47:0]        o_sum_abs,
    output logic [31:0]        o_sample_count,
    output logic [15:0]        o_max_abs,
    output logic signed [15:0] o_ring_sample,
    output logic               o_sample_valid,
    output logic [6:0]         o_copied,
    output logic               o_is_last
);
    import aasr_pkg::*;

    // front to queue
    logic  q_push;
    t_cmd  q_cmd;
    logic  q_full;
    // queue to back
    t_cmd  head;
    logic  head_valid;
    logic  pop;

    // decode, take magnitude, clamp burst length
    aasr_front #(
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_sample    (i_sample),
        .i_max_count (i_max_count),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_cmd       (q_cmd)
    );

    // hold decoded commands until the execution unit is free
    aasr_cmd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_cmd        (q_cmd),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_full       (q_full)
    );

    // statistics, ring memory and the read burst sequencer
    aasr_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_head_valid    (head_valid),
        .o_pop           (pop),
        .o_result_strobe (o_result_strobe),
        .o_sum_abs       (o_sum_abs),
        .o_sample_count  (o_sample_count),
        .o_max_abs       (o_max_abs),
        .o_ring_sample   (o_ring_sample),
        .o_sample_valid  (o_sample_valid),
        .o_copied        (o_copied),
        .o_is_last       (o_is_last)
    );

endmodule

### bench/tb_audio_abs_stats_and_sample_ring.sv
module tb_audio_abs_stats_and_sample_ring;
    timeunit 1ns;
    timeprecision 1ps;

    import aasr_pkg::*;

    localparam int RING_DEPTH = 512;
    localparam int MAX_BURST  = 64;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    // Code 3 has no member in the package enum: the block takes it and ignores it.
    localparam logic [1:0]  OP_UNUSED = 2'd3;
    localparam logic [47:0] SUM_FULL  = {48{1'b1}};
    localparam logic [31:0] CNT_FULL  = {32{1'b1}};

    // Stretch of random items during which the sender never idles.
    localparam int STEADY_FROM  = 180;
    localparam int STEADY_TO    = 260;
    // Random items after the directed table; about 310 items in all.
    localparam int RANDOM_ITEMS = 287;

    // One result beat, field for field as the block presents it.
    typedef struct packed {
        logic [47:0] sum_abs;
        logic [31:0] sample_count;
        logic [15:0] max_abs;
        logic [15:0] ring_sample;
        logic        sample_valid;
        logic [6:0]  copied;
        logic        is_last;
    } t_beat;

    // One row of the directed table. Where typed is set, beat is the result the
    // row must give, and it stands in for the predicted one.
    typedef struct {
        logic [1:0] op;
        logic [15:0] smp;
        logic [6:0]  cnt;
        bit          typed;
        t_beat       beat;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_operation;
    logic signed [15:0] i_sample;
    logic [6:0]         i_max_count;
    logic               o_result_strobe;
    logic [47:0]        o_sum_abs;
    logic [31:0]        o_sample_count;
    logic [15:0]        o_max_abs;
    logic signed [15:0] o_ring_sample;
    logic               o_sample_valid;
    logic [6:0]         o_copied;
    logic               o_is_last;

    audio_abs_stats_and_sample_ring #(
        .RING_DEPTH(RING_DEPTH),
        .MAX_BURST (MAX_BURST)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_sample       (i_sample),
        .i_max_count    (i_max_count),
        .o_result_strobe(o_result_strobe),
        .o_sum_abs      (o_sum_abs),
        .o_sample_count (o_sample_count),
        .o_max_abs      (o_max_abs),
        .o_ring_sample  (o_ring_sample),
        .o_sample_valid (o_sample_valid),
        .o_copied       (o_copied),
        .o_is_last      (o_is_last)
    );

    // Shadow state of the block: level statistics, ring contents, positions.
    logic [47:0] level_sum;
    logic [31:0] level_count;
    logic [15:0] level_peak;
    logic [15:0] ring_copy [RING_DEPTH];
    logic [31:0] wr_pos;
    logic [31:0] rd_pos;

    t_beat       fresh_beats[$];     // beats the last command gives
    t_beat       expected_beats[$];  // beats owed by the block, oldest first
    t_stim_row   directed_rows[$];
    int          fault_count;
    bit          idle_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Work out what one accepted command does to the shadow state and which
    // beats it owes. Leave them in fresh_beats for the caller to queue.
    task automatic predict_outcome(input logic [1:0] op, input logic [15:0] raw,
                                   input logic [6:0] cnt);
        logic [16:0] mag;
        logic [31:0] unread;
        logic [31:0] take;
        logic [31:0] lim;
        logic [31:0] idx;
        t_beat       b;
        fresh_beats.delete();
        b = '0;
        case (op)
            OP_PUSH: begin
                // -32768 folds to 32768, which still fits the 16-bit peak.
                mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
                if (SUM_FULL - level_sum < 48'(mag)) begin
                    level_sum = SUM_FULL;
                end else begin
                    level_sum = level_sum + 48'(mag);
                end
                if (level_count != CNT_FULL) begin
                    level_count = level_count + 32'd1;
                end
                if (mag > {1'b0, level_peak}) begin
                    level_peak = mag[15:0];
                end
                ring_copy[wr_pos[RING_AW-1:0]] = raw;
                wr_pos = wr_pos + 32'd1;
            end
            OP_DRAIN: begin
                b.sum_abs      = level_sum;
                b.sample_count = level_count;
                b.max_abs      = level_peak;
                b.is_last      = 1'b1;
                fresh_beats.push_back(b);
                level_sum   = '0;
                level_count = '0;
                level_peak  = '0;
            end
            OP_READ: begin
                lim    = (cnt > MAX_BURST) ? MAX_BURST : 32'(cnt);
                unread = wr_pos - rd_pos;
                if (unread == 0 || lim == 0) begin
                    // Empty read: one closing beat, positions untouched.
                    b.is_last = 1'b1;
                    fresh_beats.push_back(b);
                end else begin
                    // Reader lapped: skip ahead to the oldest sample still held.
                    if (unread > RING_DEPTH) begin
                        rd_pos = wr_pos - RING_DEPTH;
                        unread = RING_DEPTH;
                    end
                    take = (unread < lim) ? unread : lim;
                    for (int i = 0; i < take; i++) begin
                        idx            = rd_pos + i;
                        b.ring_sample  = ring_copy[idx[RING_AW-1:0]];
                        b.sample_valid = 1'b1;
                        b.copied       = take[6:0];
                        b.is_last      = (i + 1 == take);
                        fresh_beats.push_back(b);
                    end
                    rd_pos = rd_pos + take;
                end
            end
            default: begin
            end
        endcase
    endtask

    // Offer one command: idle at random first, then hold start high until the
    // block takes it, then queue what it owes.
    task automatic drive_item(input logic [1:0] op, input logic [15:0] smp,
                              input logic [6:0] cnt, input bit typed, input t_beat typed_beat);
        @(negedge i_clk);
        while (idle_on && $urandom_range(99, 0) < 35) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_sample    <= smp;
        i_max_count <= cnt;
        // Hold the command until an edge finds busy low.
        do begin
            @(posedge i_clk);
        end while (busy);
        predict_outcome(op, smp, cnt);
        if (typed) begin
            expected_beats.push_back(typed_beat);
        end else begin
            foreach (fresh_beats[k]) expected_beats.push_back(fresh_beats[k]);
        end
    endtask

    task automatic add_row(input logic [1:0] op, input logic [15:0] smp, input logic [6:0] cnt,
                           input bit typed, input t_beat beat);
        t_stim_row row;
        row.op    = op;
        row.smp   = smp;
        row.cnt   = cnt;
        row.typed = typed;
        row.beat  = beat;
        directed_rows.push_back(row);
    endtask

    // Single closing beat: a drain with the given statistics, or with all
    // zeros an empty read.
    function automatic t_beat lone_beat(input logic [47:0] sum, input logic [31:0] count,
                                        input logic [15:0] peak);
        t_beat b;
        b              = '0;
        b.sum_abs      = sum;
        b.sample_count = count;
        b.max_abs      = peak;
        b.is_last      = 1'b1;
        return b;
    endfunction

    // Mostly uniform samples, with the edges of the range now and then.
    function automatic logic [15:0] rand_sample();
        case ($urandom_range(19, 0))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Burst limits: mostly short, some full bursts, some zero, some above the cap.
    function automatic logic [6:0] rand_limit();
        int r;
        r = $urandom_range(99, 0);
        if (r < 60) return 7'($urandom_range(16, 1));
        if (r < 75) return 7'($urandom_range(64, 17));
        if (r < 85) return 7'(MAX_BURST);
        if (r < 90) return 7'd0;
        return 7'($urandom_range(127, 65));
    endfunction

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fault_count++;
        end
    endtask

    // Sample every result beat at the edge that ends its cycle and match it
    // against the oldest beat still owed.
    always @(posedge i_clk) begin : beat_monitor
        t_beat seen;
        t_beat want;
        if (i_rst_n && o_result_strobe) begin
            seen = {o_sum_abs, o_sample_count, o_max_abs, o_ring_sample,
                    o_sample_valid, o_copied, o_is_last};
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing owed: 0x%0h", seen);
                fault_count++;
            end else begin
                want = expected_beats.pop_front();
                check_field("sum_abs",      want.sum_abs,      seen.sum_abs);
                check_field("sample_count", want.sample_count, seen.sample_count);
                check_field("max_abs",      want.max_abs,      seen.max_abs);
                check_field("ring_sample",  want.ring_sample,  seen.ring_sample);
                check_field("sample_valid", want.sample_valid, seen.sample_valid);
                check_field("copied",       want.copied,       seen.copied);
                check_field("is_last",      want.is_last,      seen.is_last);
            end
        end
    end

    // Generous bound: far beyond a run of full 64-beat reads with idling.
    initial begin
        #8_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int  random_items;
        int  run_len;
        int  r;

        start       = 1'b0;
        i_operation = OP_PUSH;
        i_sample    = '0;
        i_max_count = '0;
        i_rst_n     = 1'b0;
        idle_on     = 1'b1;
        fault_count = 0;
        level_sum   = '0;
        level_count = '0;
        level_peak  = '0;
        wr_pos      = '0;
        rd_pos      = '0;
        random_items = 0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: reset state, edges of the sample range, zero and
        // oversized limits, empty reads and the ignored code.
        add_row(OP_DRAIN,  16'h0000, 7'd0,   1, lone_beat(48'd0, 32'd0, 16'd0));
        add_row(OP_READ,   16'h0000, 7'd5,   1, lone_beat(48'd0, 32'd0, 16'd0));
        add_row(OP_UNUSED, 16'hFFFF, 7'd127, 0, '0);
        add_row(OP_PUSH,   16'h8000, 7'd0,   0, '0);
        add_row(OP_DRAIN,  16'h0000, 7'd0,   1, lone_beat(48'd32768, 32'd1, 16'd32768));
        add_row(OP_PUSH,   16'h7FFF, 7'd0,   0, '0);
        add_row(OP_PUSH,   16'h0000, 7'd0,   0, '0);
        add_row(OP_PUSH,   16'hFFFF, 7'd0,   0, '0);
        add_row(OP_PUSH,   16'h0001, 7'd127, 0, '0);
        add_row(OP_DRAIN,  16'h0000, 7'd0,   1, lone_beat(48'd32769, 32'd4, 16'd32767));
        add_row(OP_READ,   16'h0000, 7'd0,   1, lone_beat(48'd0, 32'd0, 16'd0));
        add_row(OP_READ,   16'h0000, 7'd2,   0, '0);
        add_row(OP_UNUSED, 16'h7FFF, 7'd64,  0, '0);
        add_row(OP_READ,   16'h0000, 7'd127, 0, '0);
        add_row(OP_READ,   16'h0000, 7'd64,  1, lone_beat(48'd0, 32'd0, 16'd0));
        add_row(OP_PUSH,   16'h5555, 7'd0,   0, '0);
        add_row(OP_PUSH,   16'hAAAA, 7'd0,   0, '0);
        add_row(OP_READ,   16'h0000, 7'd1,   0, '0);
        add_row(OP_DRAIN,  16'h0000, 7'd0,   0, '0);
        add_row(OP_READ,   16'h0000, 7'd64,  0, '0);
        add_row(OP_DRAIN,  16'h0000, 7'd0,   1, lone_beat(48'd0, 32'd0, 16'd0));
        add_row(OP_PUSH,   16'hFFFE, 7'd0,   0, '0);
        add_row(OP_READ,   16'h0000, 7'd100, 0, '0);

        foreach (directed_rows[n]) begin
            drive_item(directed_rows[n].op, directed_rows[n].smp, directed_rows[n].cnt,
                       directed_rows[n].typed, directed_rows[n].beat);
        end

        // Random part: runs of pushes broken by reads, drains and the odd
        // ignored code.
        while (random_items < RANDOM_ITEMS) begin
            idle_on = !(random_items >= STEADY_FROM && random_items < STEADY_TO);
            r = $urandom_range(99, 0);
            if (r < 55) begin
                run_len = $urandom_range(24, 1);
                repeat (run_len) begin
                    drive_item(OP_PUSH, rand_sample(), 7'($urandom), 0, '0);
                    random_items++;
                end
            end else if (r < 85) begin
                drive_item(OP_READ, 16'($urandom), rand_limit(), 0, '0);
                random_items++;
            end else if (r < 95) begin
                drive_item(OP_DRAIN, 16'($urandom), 7'($urandom), 0, '0);
                random_items++;
            end else begin
                // Taken and ignored by the block.
                drive_item(OP_UNUSED, 16'($urandom), 7'($urandom), 0, '0);
                random_items++;
            end
        end

        // Drop start once the last command is taken, drain the owed beats,
        // then give stray beats a chance to show.
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);

        if (fault_count == 0 && expected_beats.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
